/* src/assert_macros.svh */
// Assertion macros used by the checker file etf_chk.sv.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ETF_AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ETF_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/etf_pkg.sv */
// Package for the totient block: field widths and the default datapath width.
// No dependencies.
package etf_pkg;

	localparam int NUMBER_W         = 32;
	localparam int TOTIENT_W        = 32;
	localparam int DATA_WIDTH_DEF   = 32;

endpackage

/* src/etf_if.sv */
// Valid/ready channel interfaces for the totient block: request and response.
// Depends on etf_pkg for the field widths.
interface etf_req_if;
	logic                          valid;
	logic                          ready;
	logic [etf_pkg::NUMBER_W-1:0]  number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface etf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [etf_pkg::TOTIENT_W-1:0] totient;

	modport source (output valid, output totient, input ready);
	modport sink   (input valid, input totient, output ready);
endinterface

/* src/etf_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the totient sequencer.
// No package dependencies; width comes from the parent.
module etf_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// dividend shifts out of the top of quo_q while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* src/euler_totient_trial_division.sv */
// Channel   Dir  Payload             Handshake
// req       in   number  [31:0]      valid/ready, taken when both high
// rsp       out  totient [31:0]      valid/ready, taken when both high
//
// One item at a time. Each candidate divisor d costs one pass of the shared
// divider, and an item takes one pass for each d from 2 up to floor(sqrt(n)),
// plus one division per repeated prime factor and per distinct prime.
// Reset clears the sequencer and the output valid; no clearing pass.
// req.ready is high only while idle; a finished result waits in the output
// register while the next item is taken, and the sequencer holds if it is still full.
// Depends on etf_pkg, etf_if and etf_div.
module euler_totient_trial_division #(
	parameter int DATA_WIDTH = etf_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	etf_req_if.sink    req,
	etf_rsp_if.source  rsp
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = DATA_WIDTH + 2;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CHECK  = 6'b000010,
		S_DIVR   = 6'b000100,
		S_DIVA   = 6'b001000,
		S_DIVF   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t        state_q;
	logic [DW-1:0] value_q;
	logic [DW-1:0] rest_q;
	logic [DW-1:0] ans_q;
	logic [DW-1:0] d_q;
	logic [SW-1:0] sq_q;
	logic          found_q;
	logic [DW-1:0] out_q;
	logic          out_valid_q;

	logic [DW-1:0] in_value;
	logic          div_start;
	logic [DW-1:0] div_dvd;
	logic [DW-1:0] div_dsr;
	logic          div_done;
	logic [DW-1:0] div_quot;
	logic [DW-1:0] div_rem;
	logic          in_loop;
	logic [SW-1:0] sq_next;

	generate
		if (DW > etf_pkg::NUMBER_W) begin : g_in_ext
			assign in_value = {{(DW - etf_pkg::NUMBER_W){1'b0}}, req.number};
		end else begin : g_in_cut
			assign in_value = req.number[DW-1:0];
		end
		if (DW >= etf_pkg::TOTIENT_W) begin : g_out_cut
			assign rsp.totient = out_q[etf_pkg::TOTIENT_W-1:0];
		end else begin : g_out_ext
			assign rsp.totient = {{(etf_pkg::TOTIENT_W - DW){1'b0}}, out_q};
		end
	endgenerate

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;

	// d*d <= value, with d*d kept incrementally: (d+1)^2 = d^2 + 2d + 1
	assign in_loop = (sq_q <= {2'b00, value_q});
	assign sq_next = sq_q + {1'b0, d_q, 1'b1};

	always_comb begin
		div_start = 1'b0;
		div_dvd   = rest_q;
		div_dsr   = d_q;
		case (state_q)
			S_CHECK: begin
				if (in_loop) begin
					div_start = 1'b1;
				end else if (rest_q > DW'(1)) begin
					div_start = 1'b1;
					div_dvd   = ans_q;
					div_dsr   = rest_q;
				end
			end
			S_DIVR: begin
				if (div_done) begin
					if (div_rem == '0) begin
						div_start = 1'b1;
						div_dvd   = div_quot;
					end else if (found_q) begin
						div_start = 1'b1;
						div_dvd   = ans_q;
					end
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	etf_div #(
		.W (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (in_loop) begin
						state_q <= S_DIVR;
					end else if (rest_q > DW'(1)) begin
						state_q <= S_DIVF;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DIVR: begin
					if (div_done && div_rem != '0) begin
						state_q <= found_q ? S_DIVA : S_CHECK;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_DIVF: begin
					if (div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// answer/d is exact here, so answer/d*(d-1) is answer - answer/d
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					value_q <= in_value;
					rest_q  <= in_value;
					ans_q   <= in_value;
					d_q     <= DW'(2);
					sq_q    <= SW'(4);
					found_q <= 1'b0;
				end
			end
			S_DIVR: begin
				if (div_done) begin
					if (div_rem == '0) begin
						rest_q  <= div_quot;
						found_q <= 1'b1;
					end else if (!found_q) begin
						d_q  <= d_q + DW'(1);
						sq_q <= sq_next;
					end
				end
			end
			S_DIVA: begin
				if (div_done) begin
					ans_q   <= ans_q - div_quot;
					found_q <= 1'b0;
					d_q     <= d_q + DW'(1);
					sq_q    <= sq_next;
				end
			end
			S_DIVF: begin
				if (div_done) begin
					ans_q <= ans_q - div_quot;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_q <= ans_q;
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

endmodule

/* src/etf_chk.sv */
// Port-level checker for the totient block, bound to the top level.
// Depends on etf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [etf_pkg::TOTIENT_W-1:0] rsp_totient
);

	// a stalled result stays offered and unchanged
	`ETF_AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
	`ETF_AST_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_totient), "rsp item changed while stalled")

	// one item at a time: busy straight after taking an item
	`ETF_AST_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready after taking an item")

	// a new result only appears at the end of work, never out of idle
	`ETF_AST_SAME(a_rsp_from_work, $rose(rsp_valid), !$past(req_ready), "result raised while idle")

endmodule

bind euler_totient_trial_division etf_chk u_etf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_totient (rsp.totient)
);

/* test/euler_totient_trial_division_tb.sv */
// Self-checking testbench for euler_totient_trial_division: drives numbers over the
// request channel and compares each totient against a trial-division predictor.
// Depends on etf_pkg, etf_if and the block itself.
`timescale 1ns / 1ps

module euler_totient_trial_division_tb;

	localparam int DW = etf_pkg::DATA_WIDTH_DEF;
	localparam longint unsigned DW_MASK = (DW >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
		: ((64'd1 << DW) - 64'd1);
	// The slowest item is the all-ones value.
	localparam int CYCLE_LIMIT = 30_000_000;
	localparam int SMALL_PRIMES [0:9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 257};

	logic clk;
	logic arst_n;

	etf_req_if req();
	etf_rsp_if rsp();

	euler_totient_trial_division #(.DATA_WIDTH(DW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [etf_pkg::TOTIENT_W-1:0] phi_queue [$];
	int                            error_count = 0;
	int                            cycle_count;
	bit                            steady = 1'b0;  // no idling on either side while set

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [etf_pkg::TOTIENT_W-1:0] euler_phi(
		input logic [etf_pkg::NUMBER_W-1:0] n);
		longint unsigned orig;
		longint unsigned rest;
		longint unsigned acc;
		longint unsigned d;
		orig = longint'(n) & DW_MASK;
		rest = orig;
		acc  = orig;
		for (d = 2; d <= orig / d; d++) begin
			if (rest % d == 0) begin
				while (rest % d == 0)
					rest = rest / d;
				acc = acc / d * (d - 1);
			end
		end
		// whatever is left above one is a single large prime factor
		if (rest > 1)
			acc = acc / rest * (rest - 1);
		acc = acc & DW_MASK;
		return acc[etf_pkg::TOTIENT_W-1:0];
	endfunction

	function automatic int idle_cycles();
		if (steady)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic send_number(input logic [etf_pkg::NUMBER_W-1:0] value);
		int gap;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req.valid  <= 1'b0;
			req.number <= $urandom;
			repeat (gap) @(negedge clk);
		end
		req.valid  <= 1'b1;
		req.number <= value;
		do @(posedge clk); while (!req.ready);
		phi_queue.push_back(euler_phi(value));
	endtask

	// drop valid first so the last item is not taken twice once the block idles
	task automatic wait_for_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (phi_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_totient(input logic [etf_pkg::TOTIENT_W-1:0] got);
		logic [etf_pkg::TOTIENT_W-1:0] want;
		if (phi_queue.size() == 0) begin
			report($sformatf("totient %0d with no item outstanding", got));
		end else begin
			want = phi_queue.pop_front();
			if (got !== want)
				report($sformatf("totient got %0d, expected %0d", got, want));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			check_totient(rsp.totient);
	end

	// Sink side: random stall before each result
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles();
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic test_small_values();
		int v;
		for (v = 0; v <= 9; v++)
			send_number(v);
		send_number(12);
	endtask

	task automatic test_primes();
		send_number(65521);
		send_number(65537);
		send_number(1000003);
		send_number(16777213);
	endtask

	// prime powers, squares and products of many distinct primes
	task automatic test_factor_structure();
		send_number(1024);
		send_number(59049);
		send_number(49);
		send_number(65536);
		send_number(30030);
		send_number(988027);
	endtask

	// every bit set (its largest prime factor lies above the divisor bound), then zero
	task automatic test_extremes();
		send_number('1);
		send_number(0);
	endtask

	task automatic test_back_to_back();
		int i;
		steady = 1'b1;
		for (i = 0; i < 4; i++)
			send_number($urandom_range(100, 2000));
		steady = 1'b0;
	endtask

	task automatic test_random();
		int i;
		int kind;
		int k;
		int p;
		logic [etf_pkg::NUMBER_W-1:0] value;
		for (i = 0; i < 75; i++) begin
			if (i % 12 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (i == 50)
				wait_for_results();
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					k = $urandom_range(1, 16);
					value = $urandom & ((32'd1 << k) - 32'd1);
				end
				6: begin
					value = $urandom_range(0, 20);
				end
				7: begin
					value = 1;
					repeat ($urandom_range(1, 4)) begin
						p = SMALL_PRIMES[$urandom_range(0, 9)];
						repeat ($urandom_range(1, 3))
							if (value * p < 32'h2_0000)
								value = value * p;
					end
				end
				8: begin
					p = $urandom_range(2, 300);
					value = p * p;
				end
				default: begin
					value = $urandom & 32'h000F_FFFF;
				end
			endcase
			send_number(value);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.number = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_small_values();
		test_primes();
		test_factor_structure();
		test_extremes();
		test_back_to_back();
		// hold the sender until the block has nothing in flight
		wait_for_results();
		test_random();

		wait_for_results();
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
